// ----- sv/ppgd_pkg.sv -----
// Shared types, constants and helpers for the sensor FIFO drain controller.
`timescale 1ns / 1ps
package ppgd_pkg;

  localparam int FIFO_DEPTH    = 32;
  localparam int BURST_SAMPLES = 5;
  localparam int SAMPLE_BYTES  = 6;
  localparam int BURST_BYTES   = BURST_SAMPLES * SAMPLE_BYTES;
  localparam int QDEPTH        = 2;

  // input action codes
  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_BYTE  = 2'd1;
  localparam logic [1:0] ACT_DONE  = 2'd2;

  // sensor registers and mode bits
  localparam logic [7:0] REG_STATUS   = 8'h00;
  localparam logic [7:0] REG_WR_PTR   = 8'h04;
  localparam logic [7:0] REG_OVF      = 8'h05;
  localparam logic [7:0] REG_RD_PTR   = 8'h06;
  localparam logic [7:0] REG_DATA     = 8'h07;
  localparam logic [7:0] REG_MODE     = 8'h09;
  localparam logic [7:0] MODE_STOP    = 8'h80;
  localparam logic [7:0] MODE_RUN     = 8'h7f;

  typedef enum logic [1:0] {
    K_READ,
    K_WRITE,
    K_SAMPLE,
    K_SUMMARY
  } kind_e;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_D_STAT,
    PH_D_PTR,
    PH_D_BURST,
    PH_R_MODE,
    PH_R_STOP,
    PH_R_P0,
    PH_R_P1,
    PH_R_P2,
    PH_R_STAT_OK,
    PH_R_STAT_BAD,
    PH_R_RES_OK,
    PH_R_RES_BAD
  } phase_e;

  typedef logic [BURST_SAMPLES-1:0][SAMPLE_BYTES-1:0][7:0] burst_t;

  // work handed from front to back: some samples, then one closing item
  typedef struct packed {
    logic [2:0] n_smp;
    burst_t     smp;
    kind_e      kind;
    logic [7:0] addr;
    logic [7:0] wval;
    logic [4:0] rlen;
    logic [5:0] cnt;
    logic [5:0] lost;
    logic       disc;
    logic       io;
  } job_t;

  function automatic logic [2:0] min_burst(input logic [5:0] n);
    return (n < 6'(BURST_SAMPLES)) ? n[2:0] : 3'(BURST_SAMPLES);
  endfunction

  function automatic logic [4:0] burst_len(input logic [2:0] s);
    return 5'({s, 2'b00}) + 5'({s, 1'b0});
  endfunction

  function automatic job_t mk_read(input logic [7:0] a, input logic [4:0] len);
    job_t j;
    j      = '0;
    j.kind = K_READ;
    j.addr = a;
    j.rlen = len;
    return j;
  endfunction

  function automatic job_t mk_write(input logic [7:0] a, input logic [7:0] v);
    job_t j;
    j      = '0;
    j.kind = K_WRITE;
    j.addr = a;
    j.wval = v;
    return j;
  endfunction

  function automatic job_t mk_summary(input logic [5:0] c, input logic [5:0] l,
                                      input logic d, input logic e);
    job_t j;
    j      = '0;
    j.kind = K_SUMMARY;
    j.cnt  = c;
    j.lost = l;
    j.disc = d;
    j.io   = e;
    return j;
  endfunction

endpackage

// ----- sv/ppgd_front.sv -----
// Front end: accepts transactions, tracks drain/recovery phase, builds jobs.
`timescale 1ns / 1ps
module ppgd_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       action_i,
  input  logic             continuity_unknown_i,
  input  logic [7:0]       capacity_i,
  input  logic [7:0]       read_byte_i,
  input  logic             bus_ok_i,
  output logic             job_valid_o,
  input  logic             job_ready_i,
  output ppgd_pkg::job_t   job_o
);

  ppgd_pkg::phase_e phase_q, phase_d;
  logic             rp_q;
  logic [7:0]       mode_q, status_q;
  logic [2:0][7:0]  ptr_q;
  logic [5:0]       unread_q, deliv_q, cap_q, flost_q;
  logic             fio_q;
  logic [4:0]       bidx_q;
  logic [2:0]       pos_q, smp_q;
  ppgd_pkg::burst_t burst_q;

  logic       acc, is_start, is_byte, is_done;
  logic [5:0] left, dnew, left2;
  logic [2:0] s_cur, s_next, s_cp;
  logic       done;
  logic [4:0] cp_ovf, cp_diff;
  logic [5:0] cp_unread, cp_lost;
  logic       cp_fault;

  logic           push, bf, bf_io, er, er_ok, rd;
  logic [5:0]     bf_lost;
  ppgd_pkg::job_t job;

  assign acc        = in_valid_i & job_ready_i;
  assign in_ready_o = job_ready_i;
  assign is_start   = acc && action_i == ppgd_pkg::ACT_START;
  assign is_byte    = acc && action_i == ppgd_pkg::ACT_BYTE;
  assign is_done    = acc && action_i == ppgd_pkg::ACT_DONE;

  // burst bookkeeping
  assign left   = unread_q - deliv_q;
  assign s_cur  = ppgd_pkg::min_burst(left);
  assign dnew   = deliv_q + {3'b000, s_cur};
  assign done   = dnew >= unread_q;
  assign left2  = unread_q - dnew;
  assign s_next = ppgd_pkg::min_burst(left2);

  // pointer check
  assign cp_ovf    = ptr_q[1][4:0];
  assign cp_diff   = ptr_q[0][4:0] - ptr_q[2][4:0];
  assign cp_unread = (cp_diff == 5'd0 && status_q[7]) ? 6'(ppgd_pkg::FIFO_DEPTH)
                                                      : {1'b0, cp_diff};
  assign cp_fault  = status_q[0] || cp_ovf != 5'd0 || cp_unread > cap_q;
  assign cp_lost   = status_q[0]      ? 6'd1 :
                     cp_ovf != 5'd0   ? {1'b0, cp_ovf} + 6'(ppgd_pkg::FIFO_DEPTH) :
                                        cp_unread;
  assign s_cp      = ppgd_pkg::min_burst(cp_unread);

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (is_start) begin
      if (phase_q == ppgd_pkg::PH_IDLE && capacity_i != 8'd0) begin
        phase_d = (rp_q || continuity_unknown_i) ? ppgd_pkg::PH_R_MODE
                                                 : ppgd_pkg::PH_D_STAT;
      end
    end else if (is_done) begin
      unique case (phase_q)
        ppgd_pkg::PH_D_STAT:
          phase_d = bus_ok_i ? ppgd_pkg::PH_D_PTR : ppgd_pkg::PH_R_MODE;
        ppgd_pkg::PH_D_PTR: begin
          if (!bus_ok_i || cp_fault)   phase_d = ppgd_pkg::PH_R_MODE;
          else if (cp_unread == 6'd0)  phase_d = ppgd_pkg::PH_IDLE;
          else                         phase_d = ppgd_pkg::PH_D_BURST;
        end
        ppgd_pkg::PH_D_BURST: begin
          if (!bus_ok_i) phase_d = ppgd_pkg::PH_R_MODE;
          else if (done) phase_d = ppgd_pkg::PH_IDLE;
          else           phase_d = ppgd_pkg::PH_D_BURST;
        end
        ppgd_pkg::PH_R_MODE:
          phase_d = bus_ok_i ? ppgd_pkg::PH_R_STOP : ppgd_pkg::PH_IDLE;
        ppgd_pkg::PH_R_STOP:
          phase_d = bus_ok_i ? ppgd_pkg::PH_R_P0 : ppgd_pkg::PH_IDLE;
        ppgd_pkg::PH_R_P0:
          phase_d = bus_ok_i ? ppgd_pkg::PH_R_P1 : ppgd_pkg::PH_R_STAT_BAD;
        ppgd_pkg::PH_R_P1:
          phase_d = bus_ok_i ? ppgd_pkg::PH_R_P2 : ppgd_pkg::PH_R_STAT_BAD;
        ppgd_pkg::PH_R_P2:
          phase_d = bus_ok_i ? ppgd_pkg::PH_R_STAT_OK : ppgd_pkg::PH_R_STAT_BAD;
        ppgd_pkg::PH_R_STAT_OK:
          phase_d = bus_ok_i ? ppgd_pkg::PH_R_RES_OK : ppgd_pkg::PH_R_RES_BAD;
        ppgd_pkg::PH_R_STAT_BAD:
          phase_d = ppgd_pkg::PH_R_RES_BAD;
        ppgd_pkg::PH_R_RES_OK,
        ppgd_pkg::PH_R_RES_BAD:
          phase_d = ppgd_pkg::PH_IDLE;
        default: phase_d = phase_q;
      endcase
    end
  end

  // job built for each transaction that yields results
  always_comb begin
    push    = 1'b0;
    job     = ppgd_pkg::mk_summary(6'd0, 6'd0, 1'b0, 1'b0);
    bf      = 1'b0;
    bf_lost = 6'd1;
    bf_io   = 1'b0;
    er      = 1'b0;
    er_ok   = 1'b0;
    if (is_start) begin
      if (phase_q == ppgd_pkg::PH_IDLE) begin
        push = 1'b1;
        if (capacity_i == 8'd0) begin
          job = ppgd_pkg::mk_summary(6'd0, 6'd0, 1'b0, 1'b0);
        end else if (rp_q || continuity_unknown_i) begin
          bf    = 1'b1;
          bf_io = rp_q;
          job   = ppgd_pkg::mk_read(ppgd_pkg::REG_MODE, 5'd1);
        end else begin
          job = ppgd_pkg::mk_read(ppgd_pkg::REG_STATUS, 5'd1);
        end
      end
    end else if (is_done) begin
      unique case (phase_q)
        ppgd_pkg::PH_D_STAT: begin
          push = 1'b1;
          if (bus_ok_i) begin
            job = ppgd_pkg::mk_read(ppgd_pkg::REG_WR_PTR, 5'd3);
          end else begin
            bf    = 1'b1;
            bf_io = 1'b1;
            job   = ppgd_pkg::mk_read(ppgd_pkg::REG_MODE, 5'd1);
          end
        end
        ppgd_pkg::PH_D_PTR: begin
          push = 1'b1;
          if (!bus_ok_i || cp_fault) begin
            bf      = 1'b1;
            bf_io   = !bus_ok_i || status_q[0];
            bf_lost = !bus_ok_i ? 6'd1 : cp_lost;
            job     = ppgd_pkg::mk_read(ppgd_pkg::REG_MODE, 5'd1);
          end else if (cp_unread == 6'd0) begin
            job = ppgd_pkg::mk_summary(6'd0, 6'd0, 1'b0, 1'b0);
          end else begin
            job = ppgd_pkg::mk_read(ppgd_pkg::REG_DATA, ppgd_pkg::burst_len(s_cp));
          end
        end
        ppgd_pkg::PH_D_BURST: begin
          push = 1'b1;
          if (!bus_ok_i) begin
            bf      = 1'b1;
            bf_io   = 1'b1;
            bf_lost = (unread_q == 6'd0) ? 6'd1 : unread_q;
            job     = ppgd_pkg::mk_read(ppgd_pkg::REG_MODE, 5'd1);
          end else begin
            if (done) job = ppgd_pkg::mk_summary(dnew, 6'd0, 1'b0, 1'b0);
            else      job = ppgd_pkg::mk_read(ppgd_pkg::REG_DATA,
                                              ppgd_pkg::burst_len(s_next));
            job.n_smp = s_cur;
            job.smp   = burst_q;
          end
        end
        ppgd_pkg::PH_R_MODE: begin
          push = 1'b1;
          if (bus_ok_i) job = ppgd_pkg::mk_write(ppgd_pkg::REG_MODE,
                                                 mode_q | ppgd_pkg::MODE_STOP);
          else          er  = 1'b1;
        end
        ppgd_pkg::PH_R_STOP: begin
          push = 1'b1;
          if (bus_ok_i) job = ppgd_pkg::mk_write(ppgd_pkg::REG_WR_PTR, 8'd0);
          else          er  = 1'b1;
        end
        ppgd_pkg::PH_R_P0: begin
          push = 1'b1;
          if (bus_ok_i) job = ppgd_pkg::mk_write(ppgd_pkg::REG_OVF, 8'd0);
          else          job = ppgd_pkg::mk_read(ppgd_pkg::REG_STATUS, 5'd1);
        end
        ppgd_pkg::PH_R_P1: begin
          push = 1'b1;
          if (bus_ok_i) job = ppgd_pkg::mk_write(ppgd_pkg::REG_RD_PTR, 8'd0);
          else          job = ppgd_pkg::mk_read(ppgd_pkg::REG_STATUS, 5'd1);
        end
        ppgd_pkg::PH_R_P2: begin
          push = 1'b1;
          job  = ppgd_pkg::mk_read(ppgd_pkg::REG_STATUS, 5'd1);
        end
        ppgd_pkg::PH_R_STAT_OK,
        ppgd_pkg::PH_R_STAT_BAD: begin
          push = 1'b1;
          job  = ppgd_pkg::mk_write(ppgd_pkg::REG_MODE, mode_q & ppgd_pkg::MODE_RUN);
        end
        ppgd_pkg::PH_R_RES_OK,
        ppgd_pkg::PH_R_RES_BAD: begin
          push  = 1'b1;
          er    = 1'b1;
          er_ok = phase_q == ppgd_pkg::PH_R_RES_OK && bus_ok_i;
        end
        default: push = 1'b0;
      endcase
      if (er) job = ppgd_pkg::mk_summary(6'd0, flost_q, 1'b1, fio_q | !er_ok);
    end
  end

  assign rd          = push && job.kind == ppgd_pkg::K_READ;
  assign job_valid_o = push;
  assign job_o       = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= ppgd_pkg::PH_IDLE;
      rp_q     <= 1'b0;
      mode_q   <= '0;
      status_q <= '0;
      ptr_q    <= '0;
      unread_q <= '0;
      deliv_q  <= '0;
      cap_q    <= '0;
      flost_q  <= '0;
      fio_q    <= 1'b0;
      bidx_q   <= '0;
      pos_q    <= '0;
      smp_q    <= '0;
    end else begin
      phase_q <= phase_d;
      if (is_start && phase_q == ppgd_pkg::PH_IDLE && capacity_i != 8'd0) begin
        cap_q <= (capacity_i > 8'(ppgd_pkg::FIFO_DEPTH)) ? 6'(ppgd_pkg::FIFO_DEPTH)
                                                         : capacity_i[5:0];
      end
      if (bf) begin
        flost_q <= bf_lost;
        fio_q   <= bf_io;
      end
      if (er) rp_q <= !er_ok;
      if (is_done && phase_q == ppgd_pkg::PH_D_PTR && bus_ok_i && !cp_fault) begin
        unread_q <= cp_unread;
        deliv_q  <= '0;
      end
      if (is_done && phase_q == ppgd_pkg::PH_D_BURST && bus_ok_i) deliv_q <= dnew;
      if (rd) begin
        bidx_q <= '0;
        pos_q  <= '0;
        smp_q  <= '0;
      end else if (is_byte && (phase_q == ppgd_pkg::PH_D_STAT ||
                               phase_q == ppgd_pkg::PH_D_PTR ||
                               phase_q == ppgd_pkg::PH_D_BURST ||
                               phase_q == ppgd_pkg::PH_R_MODE)) begin
        if (phase_q == ppgd_pkg::PH_D_STAT && bidx_q == 5'd0) status_q <= read_byte_i;
        if (phase_q == ppgd_pkg::PH_R_MODE && bidx_q == 5'd0) mode_q   <= read_byte_i;
        if (phase_q == ppgd_pkg::PH_D_PTR && bidx_q < 5'd3) ptr_q[bidx_q[1:0]] <= read_byte_i;
        if (bidx_q < 5'd31) bidx_q <= bidx_q + 5'd1;
        if (bidx_q < 5'(ppgd_pkg::BURST_BYTES)) begin
          if (pos_q == 3'(ppgd_pkg::SAMPLE_BYTES - 1)) begin
            pos_q <= '0;
            smp_q <= smp_q + 3'd1;
          end else begin
            pos_q <= pos_q + 3'd1;
          end
        end
      end
    end
  end

  // burst buffer: zeroed when a data read is issued, filled byte by byte
  always_ff @(posedge clk_i) begin
    if (rd && phase_d == ppgd_pkg::PH_D_BURST) begin
      burst_q <= '0;
    end else if (is_byte && phase_q == ppgd_pkg::PH_D_BURST &&
                 bidx_q < 5'(ppgd_pkg::BURST_BYTES)) begin
      burst_q[smp_q][pos_q] <= read_byte_i;
    end
  end

  a_burst_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == ppgd_pkg::PH_D_BURST |-> deliv_q < unread_q)
    else $error("burst phase with nothing left to drain");

  a_fault_lost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bf |=> flost_q != 6'd0)
    else $error("fault recorded with zero lost samples");

endmodule

// ----- sv/ppgd_queue.sv -----
// Two-entry job queue between front and back.
`timescale 1ns / 1ps
module ppgd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_valid_i,
  output logic           wr_ready_o,
  input  ppgd_pkg::job_t wr_data_i,
  output logic           rd_valid_o,
  input  logic           rd_ready_i,
  output ppgd_pkg::job_t rd_data_o
);

  ppgd_pkg::job_t slot_q [ppgd_pkg::QDEPTH];
  logic           wp_q, rp_q;
  logic [1:0]     cnt_q;
  logic           wr, rd;

  assign wr_ready_o = cnt_q != 2'(ppgd_pkg::QDEPTH);
  assign rd_valid_o = cnt_q != 2'd0;
  assign rd_data_o  = slot_q[rp_q];
  assign wr         = wr_valid_i & wr_ready_o;
  assign rd         = rd_valid_o & rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr) slot_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(wr) - 2'(rd);
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(ppgd_pkg::QDEPTH))
    else $error("queue count out of range");

endmodule

// ----- sv/ppgd_back.sv -----
// Back end: expands a job into sample items and its closing item.
`timescale 1ns / 1ps
module ppgd_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_valid_i,
  output logic           job_ready_o,
  input  ppgd_pkg::job_t job_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [1:0]     kind_o,
  output logic [7:0]     reg_address_o,
  output logic [7:0]     write_value_o,
  output logic [4:0]     read_length_o,
  output logic [17:0]    red_o,
  output logic [17:0]    infrared_o,
  output logic [5:0]     sample_count_o,
  output logic [5:0]     drop_count_o,
  output logic           discontinuity_o,
  output logic           bus_fault_o,
  output logic           last_o
);

  logic        out_valid_q;
  logic [2:0]  idx_q;
  logic        load, take, is_tail;
  logic [ppgd_pkg::SAMPLE_BYTES*8-1:0] cur;

  ppgd_pkg::kind_e kind_q;
  logic [7:0]  addr_q, wval_q;
  logic [4:0]  rlen_q;
  logic [17:0] red_q, ir_q;
  logic [5:0]  cnt_q, lost_q;
  logic        disc_q, io_q, last_q;

  assign load        = !out_valid_q || out_ready_i;
  assign is_tail     = idx_q >= job_i.n_smp;
  assign take        = load && job_valid_i;
  assign job_ready_o = take && is_tail;
  assign cur         = job_i.smp[idx_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (take)             out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (take) idx_q <= is_tail ? 3'd0 : idx_q + 3'd1;
    end
  end

  // byte 0 sits in the low lane of each sample word
  always_ff @(posedge clk_i) begin
    if (take) begin
      if (is_tail) begin
        kind_q <= job_i.kind;
        addr_q <= job_i.addr;
        wval_q <= job_i.wval;
        rlen_q <= job_i.rlen;
        red_q  <= '0;
        ir_q   <= '0;
        cnt_q  <= job_i.cnt;
        lost_q <= job_i.lost;
        disc_q <= job_i.disc;
        io_q   <= job_i.io;
        last_q <= 1'b1;
      end else begin
        kind_q <= ppgd_pkg::K_SAMPLE;
        addr_q <= '0;
        wval_q <= '0;
        rlen_q <= '0;
        red_q  <= {cur[1:0], cur[15:8], cur[23:16]};
        ir_q   <= {cur[25:24], cur[39:32], cur[47:40]};
        cnt_q  <= '0;
        lost_q <= '0;
        disc_q <= 1'b0;
        io_q   <= 1'b0;
        last_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = kind_q;
  assign reg_address_o   = addr_q;
  assign write_value_o   = wval_q;
  assign read_length_o   = rlen_q;
  assign red_o           = red_q;
  assign infrared_o      = ir_q;
  assign sample_count_o  = cnt_q;
  assign drop_count_o    = lost_q;
  assign discontinuity_o = disc_q;
  assign bus_fault_o     = io_q;
  assign last_o          = last_q;

  a_sample_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && kind_q == ppgd_pkg::K_SAMPLE |-> !last_q)
    else $error("sample item marked last");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= 3'(ppgd_pkg::BURST_SAMPLES))
    else $error("sample index past burst");

endmodule

// ----- sv/ppg_sensor_fifo_drain_controller.sv -----
// Flow: an input transaction's job is written into the queue at its accepting edge and is
//   loaded from there into the output register once the back end can take it.
// Throughput: one input transaction per cycle, one result per cycle at the output register
//   while out_ready_i is high; a burst yields up to six results, buffered in a 2-job queue.
// Input ready drops only while that queue is full.
// Reset: rst_ni is asynchronous, active low; clears phase, flags, counters; no clearing pass.
`timescale 1ns / 1ps
module ppg_sensor_fifo_drain_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic        continuity_unknown_i,
  input  logic [7:0]  capacity_i,
  input  logic [7:0]  read_byte_i,
  input  logic        bus_ok_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  reg_address_o,
  output logic [7:0]  write_value_o,
  output logic [4:0]  read_length_o,
  output logic [17:0] red_o,
  output logic [17:0] infrared_o,
  output logic [5:0]  sample_count_o,
  output logic [5:0]  drop_count_o,
  output logic        discontinuity_o,
  output logic        bus_fault_o,
  output logic        last_o
);

  // front -> queue
  logic           fq_valid, fq_ready;
  ppgd_pkg::job_t fq_job;
  // queue -> back
  logic           qb_valid, qb_ready;
  ppgd_pkg::job_t qb_job;

  // front: owns all drain/recovery state, one transaction per cycle while the queue has room
  ppgd_front u_front (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .action_i             (action_i),
    .continuity_unknown_i (continuity_unknown_i),
    .capacity_i           (capacity_i),
    .read_byte_i          (read_byte_i),
    .bus_ok_i             (bus_ok_i),
    .job_valid_o          (fq_valid),
    .job_ready_i          (fq_ready),
    .job_o                (fq_job)
  );

  // decouples front from a stalled output
  ppgd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fq_valid),
    .wr_ready_o (fq_ready),
    .wr_data_i  (fq_job),
    .rd_valid_o (qb_valid),
    .rd_ready_i (qb_ready),
    .rd_data_o  (qb_job)
  );

  // back: serializes samples then the closing command or summary
  ppgd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_valid_i     (qb_valid),
    .job_ready_o     (qb_ready),
    .job_i           (qb_job),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .kind_o          (kind_o),
    .reg_address_o   (reg_address_o),
    .write_value_o   (write_value_o),
    .read_length_o   (read_length_o),
    .red_o           (red_o),
    .infrared_o      (infrared_o),
    .sample_count_o  (sample_count_o),
    .drop_count_o    (drop_count_o),
    .discontinuity_o (discontinuity_o),
    .bus_fault_o     (bus_fault_o),
    .last_o          (last_o)
  );

endmodule

// ----- tb/ppg_sensor_fifo_drain_checker.sv -----
// Result checker for the sensor FIFO drain controller: predicts and compares.
`timescale 1ns / 1ps
module ppg_sensor_fifo_drain_checker
  import ppgd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  action_i,
  input  logic        continuity_unknown_i,
  input  logic [7:0]  capacity_i,
  input  logic [7:0]  read_byte_i,
  input  logic        bus_ok_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  reg_address_i,
  input  logic [7:0]  write_value_i,
  input  logic [4:0]  read_length_i,
  input  logic [17:0] red_i,
  input  logic [17:0] infrared_i,
  input  logic [5:0]  sample_count_i,
  input  logic [5:0]  drop_count_i,
  input  logic        discontinuity_i,
  input  logic        bus_fault_i,
  input  logic        last_i,
  output int          errors_o,
  output int          pending_o
);

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  addr;
    logic [7:0]  wval;
    logic [4:0]  rlen;
    logic [17:0] red;
    logic [17:0] ir;
    logic [5:0]  cnt;
    logic [5:0]  lost;
    logic        disc;
    logic        io;
    logic        last;
  } drain_item_t;

  drain_item_t expected_q[$];

  phase_e     ph;
  logic       rec_pend;
  logic [7:0] mode_c, stat_c;
  logic [7:0] ptr [3];
  int         unread, deliv, bidx, capc;
  logic [7:0] bbuf [30];
  logic [5:0] flost;
  logic       fio;

  task automatic push(input kind_e k, input int a, input int w, input int n,
                      input int r, input int q, input int c, input int l,
                      input int d, input int e);
    drain_item_t it;
    it = '0;
    it.kind = k;
    it.addr = 8'(a);
    it.wval = 8'(w);
    it.rlen = 5'(n);
    it.red  = 18'(r);
    it.ir   = 18'(q);
    it.cnt  = 6'(c);
    it.lost = 6'(l);
    it.disc = 1'(d);
    it.io   = 1'(e);
    expected_q.push_back(it);
  endtask

  task automatic bus_rd(input logic [7:0] a, input int n);
    bidx = 0;
    push(K_READ, a, 0, n, 0, 0, 0, 0, 0, 0);
  endtask

  task automatic bus_wr(input logic [7:0] a, input int v);
    push(K_WRITE, a, v, 0, 0, 0, 0, 0, 0, 0);
  endtask

  task automatic start_fault(input int lost, input int e);
    flost = 6'(lost < 1 ? 1 : lost);
    fio   = 1'(e);
    ph    = PH_R_MODE;
    bus_rd(REG_MODE, 1);
  endtask

  task automatic close_recovery(input int ok);
    rec_pend = !ok;
    ph = PH_IDLE;
    push(K_SUMMARY, 0, 0, 0, 0, 0, 0, flost, 1, fio | rec_pend);
  endtask

  task automatic next_burst();
    int s;
    s = unread - deliv;
    if (s > BURST_SAMPLES) s = BURST_SAMPLES;
    foreach (bbuf[i]) bbuf[i] = '0;
    ph = PH_D_BURST;
    bus_rd(REG_DATA, s * SAMPLE_BYTES);
  endtask

  task automatic judge_pointers();
    int ovf, u;
    ovf = ptr[1] & 31;
    u = (int'(ptr[0]) - int'(ptr[2])) & 31;
    if (u == 0 && stat_c[7]) u = FIFO_DEPTH;
    if (stat_c[0]) start_fault(1, 1);
    else if (ovf != 0) start_fault(ovf + 32, 0);
    else if (u > capc) start_fault(u, 0);
    else begin
      unread = u;
      deliv  = 0;
      if (u == 0) begin
        ph = PH_IDLE;
        push(K_SUMMARY, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      end else next_burst();
    end
  endtask

  task automatic close_burst();
    int s, r, q, b;
    s = unread - deliv;
    if (s > BURST_SAMPLES) s = BURST_SAMPLES;
    for (int i = 0; i < s; i++) begin
      b = i * SAMPLE_BYTES;
      r = {bbuf[b], bbuf[b+1], bbuf[b+2]} & 'h3ffff;
      q = {bbuf[b+3], bbuf[b+4], bbuf[b+5]} & 'h3ffff;
      push(K_SAMPLE, 0, 0, 0, r, q, 0, 0, 0, 0);
    end
    deliv += s;
    if (deliv >= unread) begin
      ph = PH_IDLE;
      push(K_SUMMARY, 0, 0, 0, 0, 0, deliv, 0, 0, 0);
    end else next_burst();
  endtask

  // one accepted input transaction
  task automatic predict_drain(input logic [1:0] act, input logic cu, input logic [7:0] cap,
                               input logic [7:0] b, input logic ok);
    int n0;
    n0 = expected_q.size();
    if (act == ACT_START) begin
      if (ph == PH_IDLE) begin
        if (cap == 0) push(K_SUMMARY, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        else begin
          capc = cap > FIFO_DEPTH ? FIFO_DEPTH : cap;
          if (rec_pend || cu) start_fault(1, rec_pend);
          else begin
            ph = PH_D_STAT;
            bus_rd(REG_STATUS, 1);
          end
        end
      end
    end else if (act == ACT_BYTE) begin
      if (ph inside {PH_D_STAT, PH_D_PTR, PH_D_BURST, PH_R_MODE}) begin
        case (ph)
          PH_D_STAT:  if (bidx == 0) stat_c = b;
          PH_D_PTR:   if (bidx < 3) ptr[bidx] = b;
          PH_D_BURST: if (bidx < BURST_BYTES) bbuf[bidx] = b;
          default:    if (bidx == 0) mode_c = b;
        endcase
        if (bidx < 31) bidx++;
      end
    end else if (act == ACT_DONE) begin
      case (ph)
        PH_D_STAT:
          if (!ok) start_fault(1, 1);
          else begin
            ph = PH_D_PTR;
            bus_rd(REG_WR_PTR, 3);
          end
        PH_D_PTR:   if (ok) judge_pointers(); else start_fault(1, 1);
        PH_D_BURST: if (ok) close_burst(); else start_fault(unread, 1);
        PH_R_MODE:
          if (!ok) close_recovery(0);
          else begin
            ph = PH_R_STOP;
            bus_wr(REG_MODE, mode_c | MODE_STOP);
          end
        PH_R_STOP:
          if (!ok) close_recovery(0);
          else begin
            ph = PH_R_P0;
            bus_wr(REG_WR_PTR, 0);
          end
        PH_R_P0, PH_R_P1:
          if (ok) begin
            bus_wr(ph == PH_R_P0 ? REG_OVF : REG_RD_PTR, 0);
            ph = ph == PH_R_P0 ? PH_R_P1 : PH_R_P2;
          end else begin
            ph = PH_R_STAT_BAD;
            bus_rd(REG_STATUS, 1);
          end
        PH_R_P2: begin
          ph = ok ? PH_R_STAT_OK : PH_R_STAT_BAD;
          bus_rd(REG_STATUS, 1);
        end
        PH_R_STAT_OK, PH_R_STAT_BAD: begin
          ph = (ph == PH_R_STAT_OK && ok) ? PH_R_RES_OK : PH_R_RES_BAD;
          bus_wr(REG_MODE, mode_c & MODE_RUN);
        end
        PH_R_RES_OK, PH_R_RES_BAD: close_recovery(ph == PH_R_RES_OK && ok);
        default: ;
      endcase
    end
    if (expected_q.size() > n0) expected_q[$].last = 1'b1;
  endtask

  task automatic report(input string what, input int got, input int want);
    $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    drain_item_t w;
    if (!rst_ni) begin
      ph = PH_IDLE;
      rec_pend = 0;
      mode_c = 0;
      stat_c = 0;
      foreach (ptr[i]) ptr[i] = 0;
      foreach (bbuf[i]) bbuf[i] = 0;
      unread = 0;
      deliv = 0;
      bidx = 0;
      capc = 0;
      flost = 0;
      fio = 0;
      expected_q.delete();
      errors_o = 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) report("unexpected result", kind_i, 0);
        else begin
          w = expected_q.pop_front();
          if (kind_i != w.kind) report("kind", kind_i, w.kind);
          if (reg_address_i != w.addr) report("reg_address", reg_address_i, w.addr);
          if (write_value_i != w.wval) report("write_value", write_value_i, w.wval);
          if (read_length_i != w.rlen) report("read_length", read_length_i, w.rlen);
          if (red_i != w.red) report("red", red_i, w.red);
          if (infrared_i != w.ir) report("infrared", infrared_i, w.ir);
          if (sample_count_i != w.cnt) report("sample_count", sample_count_i, w.cnt);
          if (drop_count_i != w.lost) report("drop_count", drop_count_i, w.lost);
          if (discontinuity_i != w.disc) report("discontinuity", discontinuity_i, w.disc);
          if (bus_fault_i != w.io) report("bus_fault", bus_fault_i, w.io);
          if (last_i != w.last) report("last", last_i, w.last);
        end
      end
      if (in_valid_i && in_ready_i)
        predict_drain(action_i, continuity_unknown_i, capacity_i, read_byte_i, bus_ok_i);
      pending_o <= expected_q.size();
    end
  end

endmodule

// ----- tb/ppg_sensor_fifo_drain_controller_test.sv -----
// Testbench top: acts as the sensor bus, drives drain requests, gives the verdict.
`timescale 1ns / 1ps
module ppg_sensor_fifo_drain_controller_test;
  import ppgd_pkg::*;

  localparam logic [1:0] ACT_NONE = 2'd3;  // unused action code, ignored
  localparam int ITEMS = 280;

  // how the emulated sensor shapes its register contents
  typedef enum int {
    SNS_RANDOM, SNS_STATUS_BAD, SNS_OVERFLOW, SNS_FULL, SNS_EMPTY, SNS_BUS_FAIL
  } sensor_mode_e;

  typedef struct {
    kind_e      k;
    logic [7:0] a;
    logic [4:0] n;
  } bus_cmd_t;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        in_valid_i = 0;
  logic        in_ready_o;
  logic [1:0]  action_i = ACT_NONE;
  logic        continuity_unknown_i = 0;
  logic [7:0]  capacity_i = 0;
  logic [7:0]  read_byte_i = 0;
  logic        bus_ok_i = 0;
  logic        out_valid_o;
  logic        out_ready_i = 0;
  logic [1:0]  kind_o;
  logic [7:0]  reg_address_o, write_value_o;
  logic [4:0]  read_length_o;
  logic [17:0] red_o, infrared_o;
  logic [5:0]  sample_count_o, drop_count_o;
  logic        discontinuity_o, bus_fault_o, last_o;
  int          errors, pending;

  bus_cmd_t     cmd_q[$];
  int           drive_cnt = 0;
  bit           no_gap = 0;      // stretch with no idling on either side
  bit           hold_req = 0;    // ask the receiver for a long back-pressure stretch
  bit           flooded = 0;     // the flood stretch has run
  sensor_mode_e smode = SNS_RANDOM;
  logic [7:0]   wr_ptr;

  always #10 clk_i = ~clk_i;

  ppg_sensor_fifo_drain_controller i_dut (.*);

  ppg_sensor_fifo_drain_checker i_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .action_i,
    .continuity_unknown_i, .capacity_i, .read_byte_i, .bus_ok_i,
    .out_valid_i(out_valid_o), .out_ready_i, .kind_i(kind_o),
    .reg_address_i(reg_address_o), .write_value_i(write_value_o),
    .read_length_i(read_length_o), .red_i(red_o), .infrared_i(infrared_o),
    .sample_count_i(sample_count_o), .drop_count_i(drop_count_o),
    .discontinuity_i(discontinuity_o), .bus_fault_i(bus_fault_o), .last_i(last_o),
    .errors_o(errors), .pending_o(pending)
  );

  // Waits for a rising clock edge; collects bus commands seen on the result channel so the
  // emulated sensor can answer them. Returns 1 if the offered input was taken.
  task automatic tick(output bit taken);
    bus_cmd_t c;
    @(posedge clk_i);
    taken = in_valid_i && in_ready_o;
    if (out_valid_o && out_ready_i && (kind_o == K_READ || kind_o == K_WRITE)) begin
      c.k = kind_e'(kind_o);
      c.a = reg_address_o;
      c.n = read_length_o;
      cmd_q.push_back(c);
    end
  endtask

  // Offer one input transaction and hold it until accepted.
  task automatic send(input logic [1:0] act, input logic cu, input logic [7:0] cap,
                      input logic [7:0] b, input logic ok);
    int gap;
    bit taken;
    gap = no_gap ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) tick(taken);
    end
    in_valid_i           <= 1'b1;
    action_i             <= act;
    continuity_unknown_i <= cu;
    capacity_i           <= cap;
    read_byte_i          <= b;
    bus_ok_i             <= ok;
    do tick(taken); while (!taken);
    if (act != ACT_NONE) drive_cnt++;
  endtask

  // Register contents returned by the emulated sensor.
  function automatic logic [7:0] sensor_byte(input logic [7:0] a, input int idx,
                                             input int len);
    logic [7:0] v;
    v = 8'($urandom);
    if (len == 1 && a == REG_STATUS) begin
      if (smode == SNS_STATUS_BAD) v[0] = 1'b1;
      else if (smode == SNS_FULL) v = (v | 8'h80) & 8'hfe;
      else if ($urandom_range(0, 9) != 0) v[0] = 1'b0;
    end else if (len == 3 && a == REG_WR_PTR) begin
      if (idx == 0) begin
        wr_ptr = v;
      end else if (idx == 1) begin
        if (smode == SNS_OVERFLOW) v[4:0] = 5'd31;
        else if (smode != SNS_RANDOM || $urandom_range(0, 7) != 0) v[4:0] = 5'd0;
      end else begin
        if (smode == SNS_FULL || smode == SNS_EMPTY) v = wr_ptr;
        else if ($urandom_range(0, 15) == 0) v = wr_ptr - 8'($urandom_range(13, 31));
        else v = wr_ptr - 8'($urandom_range(0, 12));
      end
    end
    return v;
  endfunction

  // Answer one bus command: data bytes for a read (now and then a stray byte for a write), then the finish event.
  task automatic answer(input bus_cmd_t c);
    int len;
    logic ok;
    len = c.n;
    if (c.k == K_READ && $urandom_range(0, 15) == 0)
      len = $urandom_range(0, 1) ? len + 1 : (len > 0 ? len - 1 : 0);
    if (c.k == K_WRITE && $urandom_range(0, 15) == 0) len = 1;  // stray byte
    for (int i = 0; i < len; i++)
      send(ACT_BYTE, 1'($urandom), 8'($urandom), sensor_byte(c.a, i, len), 1'($urandom));
    ok = smode == SNS_BUS_FAIL ? 1'b0 : ($urandom_range(0, 15) != 0);
    send(ACT_DONE, 1'($urandom), 8'($urandom), 8'($urandom), ok);
  endtask

  // Keep answering until no bus command is queued and no result is pending.
  task automatic settle();
    int quiet;
    bit taken;
    quiet = 0;
    while (quiet < 4) begin
      if (cmd_q.size() > 0) begin
        answer(cmd_q.pop_front());
        quiet = 0;
      end else begin
        in_valid_i <= 1'b0;
        tick(taken);
        quiet = (pending == 0) ? quiet + 1 : 0;
      end
    end
  endtask

  task automatic drain(input logic [7:0] cap, input logic cu, input sensor_mode_e m);
    smode = m;
    send(ACT_START, cu, cap, 8'($urandom), 1'($urandom));
    settle();
    smode = SNS_RANDOM;
  endtask

  // receiver: random stall per result, plus one long hold-off on request
  initial begin
    int gap;
    forever begin
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (150) @(posedge clk_i);
        hold_req = 0;
      end
      gap = no_gap ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin
    #(20ns * 600000);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    bit taken;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: ignored actions while idle, then each drain outcome
    send(ACT_NONE, 1'b1, 8'hff, 8'hff, 1'b1);
    send(ACT_BYTE, 1'b0, 8'h00, 8'h00, 1'b0);
    send(ACT_DONE, 1'b1, 8'hff, 8'hff, 1'b1);
    settle();
    drain(8'd0, 1'b1, SNS_RANDOM);
    drain(8'd255, 1'b0, SNS_FULL);
    drain(8'd1, 1'b0, SNS_FULL);
    drain(8'd32, 1'b0, SNS_EMPTY);
    drain(8'd40, 1'b0, SNS_STATUS_BAD);
    drain(8'd40, 1'b0, SNS_OVERFLOW);
    drain(8'd12, 1'b1, SNS_RANDOM);
    drain(8'd12, 1'b0, SNS_BUS_FAIL);  // failed recovery leaves the sticky flag
    drain(8'd12, 1'b0, SNS_RANDOM);

    // random: mostly well-formed drains, some noise
    while (drive_cnt < ITEMS) begin
      if (drive_cnt > 140 && !flooded && pending == 0) begin
        // sender waits for everything, then floods while the receiver stalls
        settle();
        flooded  = 1;
        hold_req = 1;
        repeat (8) send(ACT_START, 1'($urandom), 8'd0, 8'($urandom), 1'($urandom));
        settle();
      end
      no_gap = drive_cnt > 200 && drive_cnt < 240;
      if (cmd_q.size() > 0) answer(cmd_q.pop_front());
      else if ($urandom_range(0, 7) == 0)
        send($urandom_range(0, 1) ? ACT_NONE : ACT_START, 1'($urandom),
             8'($urandom), 8'($urandom), 1'($urandom));
      else if (pending == 0)
        send(ACT_START, $urandom_range(0, 9) == 0,
             $urandom_range(0, 15) == 0 ? 8'($urandom) : 8'($urandom_range(0, 34)),
             8'($urandom), 1'($urandom));
      else begin
        in_valid_i <= 1'b0;
        tick(taken);
      end
    end
    no_gap = 0;
    settle();
    in_valid_i <= 1'b0;
    repeat (10) tick(taken);

    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/ppgd_pkg.sv
sv/ppgd_front.sv
sv/ppgd_queue.sv
sv/ppgd_back.sv
sv/ppg_sensor_fifo_drain_controller.sv
tb/ppg_sensor_fifo_drain_checker.sv
tb/ppg_sensor_fifo_drain_controller_test.sv
